[rtl/pid_controller_clamped_macros.svh]
// Assertion macros shared by the PID controller RTL.
`ifndef PID_CONTROLLER_CLAMPED_MACROS_SVH
`define PID_CONTROLLER_CLAMPED_MACROS_SVH

// Same-cycle implication, checked while out of reset
`define PIDC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pidc: same-cycle check failed");

// Next-cycle implication, checked while out of reset
`define PIDC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pidc: next-cycle check failed");

`endif

[rtl/pidc_pkg.sv]
// Package: widths, codes and the microcode table of the clamped PID controller.
`timescale 1ns / 1ps
`default_nettype none

package pidc_pkg;

    // Word format
    localparam int DATA_W   = 32;
    localparam int FRAC_W   = 16;
    localparam int DT_W     = DATA_W - 1;
    localparam int ERR_W    = DATA_W + 1;
    localparam int DIFF_W   = DATA_W + 2;
    localparam int INTEG_W  = 48;

    // Shared multiplier: A magnitude times one chunk of B magnitude per cycle
    localparam int MA_W     = ERR_W;
    localparam int MB_W     = INTEG_W;
    localparam int CHUNK_W  = 16;
    localparam int NCHUNK   = MB_W / CHUNK_W;
    localparam int K_W      = $clog2(NCHUNK);
    localparam int PART_W   = MA_W + CHUNK_W;
    localparam int ACC_W    = MA_W + MB_W;
    localparam int TMAG_W   = 61;
    localparam int SUM_W    = TMAG_W + 2;

    // Serial divider for the derivative
    localparam int NUM_W    = DIFF_W - 1 + FRAC_W;
    localparam int REM_W    = DT_W + 1;
    localparam int CNT_W    = $clog2(NUM_W);

    localparam logic [K_W-1:0]    LAST_K    = K_W'(NCHUNK - 1);
    localparam logic [CNT_W-1:0]  DIV_FIRST = CNT_W'(NUM_W - 1);
    localparam logic [TMAG_W-1:0] TERM_MAX  = {1'b1, {(TMAG_W - 1){1'b0}}};
    localparam logic [NUM_W-1:0]  DERIV_MAX =
        {{(NUM_W - INTEG_W + 1){1'b0}}, {(INTEG_W - 1){1'b1}}};

    // Substitute for a zero elapsed time: 1 ms, at least one LSB
    localparam int DT_MIN_RAW = ((1 << FRAC_W) + 500) / 1000;
    localparam logic [DT_W-1:0] DT_MIN = DT_W'((DT_MIN_RAW == 0) ? 1 : DT_MIN_RAW);

    // Register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_PROP  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER = 3'd4;

    // Datapath micro-operations
    typedef enum logic [3:0] {
        U_NOP,
        U_LOAD,
        U_MUL_ED,
        U_MUL_STEP,
        U_INTEG,
        U_DIV_SETUP,
        U_DIV_STEP,
        U_DERIV,
        U_MUL_P,
        U_MUL_I,
        U_MUL_D,
        U_ACC,
        U_OUT,
        U_RST
    } t_uop;

    // Sequencer branch conditions
    typedef enum logic [2:0] {
        J_NEXT,
        J_WAIT_IN,
        J_IF_RST,
        J_MUL_LOOP,
        J_DIV_LOOP,
        J_OUT_WAIT,
        J_GOTO
    } t_jump;

    localparam int PC_W = 5;
    typedef logic [PC_W-1:0] t_pc;

    localparam t_pc PC_FETCH  = 5'd0;
    localparam t_pc PC_BRANCH = 5'd1;
    localparam t_pc PC_DIV    = 5'd6;
    localparam t_pc PC_DERIV  = 5'd7;
    localparam t_pc PC_OUT    = 5'd17;
    localparam t_pc PC_RST    = 5'd18;

    typedef struct packed {
        t_uop  uop;
        t_jump jmp;
        t_pc   target;
    } t_uword;

    // Control store
    function automatic t_uword ucode(input t_pc pc);
        t_uword w;
        case (pc)
            5'd0:  w = '{uop: U_LOAD,      jmp: J_WAIT_IN,  target: PC_FETCH};
            5'd1:  w = '{uop: U_NOP,       jmp: J_IF_RST,   target: PC_RST};
            5'd2:  w = '{uop: U_MUL_ED,    jmp: J_NEXT,     target: PC_FETCH};
            5'd3:  w = '{uop: U_MUL_STEP,  jmp: J_MUL_LOOP, target: PC_FETCH};
            5'd4:  w = '{uop: U_INTEG,     jmp: J_NEXT,     target: PC_FETCH};
            5'd5:  w = '{uop: U_DIV_SETUP, jmp: J_NEXT,     target: PC_FETCH};
            5'd6:  w = '{uop: U_DIV_STEP,  jmp: J_DIV_LOOP, target: PC_FETCH};
            5'd7:  w = '{uop: U_DERIV,     jmp: J_NEXT,     target: PC_FETCH};
            5'd8:  w = '{uop: U_MUL_P,     jmp: J_NEXT,     target: PC_FETCH};
            5'd9:  w = '{uop: U_MUL_STEP,  jmp: J_MUL_LOOP, target: PC_FETCH};
            5'd10: w = '{uop: U_ACC,       jmp: J_NEXT,     target: PC_FETCH};
            5'd11: w = '{uop: U_MUL_I,     jmp: J_NEXT,     target: PC_FETCH};
            5'd12: w = '{uop: U_MUL_STEP,  jmp: J_MUL_LOOP, target: PC_FETCH};
            5'd13: w = '{uop: U_ACC,       jmp: J_NEXT,     target: PC_FETCH};
            5'd14: w = '{uop: U_MUL_D,     jmp: J_NEXT,     target: PC_FETCH};
            5'd15: w = '{uop: U_MUL_STEP,  jmp: J_MUL_LOOP, target: PC_FETCH};
            5'd16: w = '{uop: U_ACC,       jmp: J_NEXT,     target: PC_FETCH};
            5'd17: w = '{uop: U_OUT,       jmp: J_OUT_WAIT, target: PC_FETCH};
            5'd18: w = '{uop: U_RST,       jmp: J_OUT_WAIT, target: PC_FETCH};
            default: w = '{uop: U_NOP,     jmp: J_GOTO,     target: PC_FETCH};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

[rtl/pid_controller_clamped.sv]
// Clamped PID controller: microcoded sequencer over a shared multiplier and serial divider.
`timescale 1ns / 1ps
`default_nettype none
//
// Input channel (i_in_valid / o_in_stall) takes one word per item: i_op selects a
// compute (0) or a clear of the integral and previous error (1). A compute word
// carries setpoint and measurement in Q16.16, elapsed time in Q15.16; zero means 1 ms.
// Output channel (o_out_valid / i_out_stall) returns one word, o_drive, per item,
// clamped to the configured bounds; a clear returns zero.
// Configuration (i_cfg_valid / o_cfg_ready, i_cfg_index, i_cfg_data) writes the
// gains and clamp bounds; write it only while no item is in flight.
// Sequence: a compute word steps through the control store up to its output step,
// and the sequencer then returns to its fetch step for the next word. The restoring
// divider for the derivative and the 16-bit-chunk multiplier (four products) form its
// loops. A clear goes from the fetch and branch steps straight to the reset step.
// The input is held off while a word is in work. A finished word waits in the
// output register while the receiver stalls; the sequencer waits at its last step
// only if a second result is ready before the first is taken.
// Reset (synchronous, active low) clears the integral, the previous error, the
// output register and restores default gains (zero) and bounds (+1.0 / -1.0).
//
module pid_controller_clamped (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    // input channel
    input  wire                                  i_in_valid,
    output logic                                 o_in_stall,
    input  wire                                  i_op,
    input  wire signed [pidc_pkg::DATA_W-1:0]    i_setpoint,
    input  wire signed [pidc_pkg::DATA_W-1:0]    i_measured,
    input  wire        [pidc_pkg::DT_W-1:0]      i_elapsed,
    // output channel
    output logic                                 o_out_valid,
    input  wire                                  i_out_stall,
    output logic signed [pidc_pkg::DATA_W-1:0]   o_drive,
    // configuration channel
    input  wire                                  i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire        [pidc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire        [pidc_pkg::DATA_W-1:0]    i_cfg_data
);

    localparam int DW = pidc_pkg::DATA_W;
    localparam int FW = pidc_pkg::FRAC_W;
    localparam int IW = pidc_pkg::INTEG_W;
    localparam int SW = pidc_pkg::SUM_W;

    `include "pid_controller_clamped_macros.svh"

    // Sequencer and configuration registers
    pidc_pkg::t_pc r_pc, n_pc;
    logic signed [DW-1:0] r_kp, r_ki, r_kd, r_upper, r_lower;

    // Datapath registers
    logic                                   r_op, n_op;
    logic signed [pidc_pkg::ERR_W-1:0]      r_err, n_err;
    logic        [pidc_pkg::DT_W-1:0]       r_dt, n_dt;
    logic signed [IW-1:0]                   r_integ, n_integ;
    logic signed [pidc_pkg::ERR_W-1:0]      r_last, n_last;
    logic signed [pidc_pkg::DIFF_W-1:0]     r_diff, n_diff;
    logic signed [IW-1:0]                   r_deriv, n_deriv;
    logic signed [SW-1:0]                   r_sum, n_sum;
    logic        [pidc_pkg::MA_W-1:0]       r_ma, n_ma;
    logic        [pidc_pkg::MB_W-1:0]       r_mb, n_mb;
    logic                                   r_neg, n_neg;
    logic        [pidc_pkg::ACC_W-1:0]      r_acc, n_acc;
    logic        [pidc_pkg::K_W-1:0]        r_k, n_k;
    logic        [pidc_pkg::NUM_W-1:0]      r_num, n_num;
    logic        [pidc_pkg::REM_W-1:0]      r_rem, n_rem;
    logic        [pidc_pkg::NUM_W-1:0]      r_quo, n_quo;
    logic        [pidc_pkg::CNT_W-1:0]      r_cnt, n_cnt;
    logic signed [DW-1:0]                   r_drive, n_drive;
    logic                                   r_out_valid, n_out_valid;

    // Combinational helpers
    pidc_pkg::t_uword                       w_uw;
    logic                                   w_in_acc;
    logic                                   w_out_free;
    logic        [pidc_pkg::CHUNK_W-1:0]    w_chunk;
    logic        [pidc_pkg::PART_W-1:0]     w_part;
    logic        [pidc_pkg::ACC_W-1:0]      w_part_sh;
    logic        [pidc_pkg::ACC_W-FW-1:0]   w_q;
    logic        [pidc_pkg::TMAG_W-1:0]     w_tmag;
    logic signed [SW-1:0]                   w_term;
    logic signed [SW-1:0]                   w_isum;
    logic signed [pidc_pkg::DIFF_W-1:0]     w_diff;
    logic        [pidc_pkg::DIFF_W-1:0]     w_dmag;
    logic        [pidc_pkg::REM_W-1:0]      w_rem_sh;
    logic                                   w_ge;
    logic        [pidc_pkg::NUM_W-1:0]      w_qsat;
    logic signed [SW-1:0]                   w_lo, w_hi;

    assign o_in_stall  = (r_pc != pidc_pkg::PC_FETCH) || !i_rst_n;
    assign o_cfg_ready = i_rst_n;
    assign o_out_valid = r_out_valid;
    assign o_drive     = r_drive;

    assign w_uw       = pidc_pkg::ucode(r_pc);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    // Multiplier chunk product and its scaled, saturated signed term
    assign w_chunk   = r_mb[{r_k, {$clog2(pidc_pkg::CHUNK_W){1'b0}}} +: pidc_pkg::CHUNK_W];
    assign w_part    = pidc_pkg::PART_W'(r_ma) * pidc_pkg::PART_W'(w_chunk);
    assign w_part_sh = {{(pidc_pkg::ACC_W - pidc_pkg::PART_W){1'b0}}, w_part}
                       << {r_k, {$clog2(pidc_pkg::CHUNK_W){1'b0}}};
    assign w_q       = r_acc[pidc_pkg::ACC_W-1:FW];
    assign w_tmag    = (w_q > (pidc_pkg::ACC_W - FW)'(pidc_pkg::TERM_MAX))
                       ? pidc_pkg::TERM_MAX : w_q[pidc_pkg::TMAG_W-1:0];
    assign w_term    = r_neg ? -$signed({2'b00, w_tmag}) : $signed({2'b00, w_tmag});

    // Integral update before saturation
    assign w_isum = $signed({{(SW - IW){r_integ[IW-1]}}, r_integ}) + w_term;

    // Error change and its magnitude
    assign w_diff = $signed({r_err[pidc_pkg::ERR_W-1], r_err})
                  - $signed({r_last[pidc_pkg::ERR_W-1], r_last});
    assign w_dmag = w_diff[pidc_pkg::DIFF_W-1] ? (~w_diff + 1'b1) : w_diff;

    // Restoring divider step
    assign w_rem_sh = {r_rem[pidc_pkg::REM_W-2:0], r_num[pidc_pkg::NUM_W-1]};
    assign w_ge     = (w_rem_sh >= {1'b0, r_dt});
    assign w_qsat   = (r_quo > pidc_pkg::DERIV_MAX) ? pidc_pkg::DERIV_MAX : r_quo;

    // Clamp bounds at sum width
    assign w_lo = $signed({{(SW - DW){r_lower[DW-1]}}, r_lower});
    assign w_hi = $signed({{(SW - DW){r_upper[DW-1]}}, r_upper});

    // Sequencer: next step
    always_comb begin
        case (w_uw.jmp)
            pidc_pkg::J_NEXT:     n_pc = pidc_pkg::t_pc'(r_pc + 1'b1);
            pidc_pkg::J_WAIT_IN:  n_pc = w_in_acc ? pidc_pkg::t_pc'(r_pc + 1'b1) : r_pc;
            pidc_pkg::J_IF_RST:   n_pc = r_op ? w_uw.target : pidc_pkg::t_pc'(r_pc + 1'b1);
            pidc_pkg::J_MUL_LOOP: n_pc = (r_k == pidc_pkg::LAST_K)
                                         ? pidc_pkg::t_pc'(r_pc + 1'b1) : r_pc;
            pidc_pkg::J_DIV_LOOP: n_pc = (r_cnt == '0)
                                         ? pidc_pkg::t_pc'(r_pc + 1'b1) : r_pc;
            pidc_pkg::J_OUT_WAIT: n_pc = w_out_free ? w_uw.target : r_pc;
            pidc_pkg::J_GOTO:     n_pc = w_uw.target;
            default:              n_pc = pidc_pkg::PC_FETCH;
        endcase
    end

    // Datapath: micro-operation decode
    always_comb begin
        n_op        = r_op;
        n_err       = r_err;
        n_dt        = r_dt;
        n_integ     = r_integ;
        n_last      = r_last;
        n_diff      = r_diff;
        n_deriv     = r_deriv;
        n_sum       = r_sum;
        n_ma        = r_ma;
        n_mb        = r_mb;
        n_neg       = r_neg;
        n_acc       = r_acc;
        n_k         = r_k;
        n_num       = r_num;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_cnt       = r_cnt;
        n_drive     = r_drive;
        // a waiting word leaves when the receiver takes it
        n_out_valid = r_out_valid && i_out_stall;

        case (w_uw.uop)
            pidc_pkg::U_LOAD: begin
                if (w_in_acc) begin
                    n_op  = i_op;
                    n_err = $signed({i_setpoint[DW-1], i_setpoint})
                          - $signed({i_measured[DW-1], i_measured});
                    n_dt  = (i_elapsed == '0) ? pidc_pkg::DT_MIN : i_elapsed;
                    n_sum = '0;
                end
            end
            pidc_pkg::U_MUL_ED: begin
                n_ma  = r_err[pidc_pkg::ERR_W-1] ? (~r_err + 1'b1) : r_err;
                n_mb  = {{(pidc_pkg::MB_W - pidc_pkg::DT_W){1'b0}}, r_dt};
                n_neg = r_err[pidc_pkg::ERR_W-1];
                n_acc = '0;
                n_k   = '0;
            end
            pidc_pkg::U_MUL_P: begin
                n_ma  = {1'b0, (r_kp[DW-1] ? (~r_kp + 1'b1) : r_kp)};
                n_mb  = {{(pidc_pkg::MB_W - pidc_pkg::ERR_W){1'b0}},
                         (r_err[pidc_pkg::ERR_W-1] ? (~r_err + 1'b1) : r_err)};
                n_neg = r_kp[DW-1] ^ r_err[pidc_pkg::ERR_W-1];
                n_acc = '0;
                n_k   = '0;
            end
            pidc_pkg::U_MUL_I: begin
                n_ma  = {1'b0, (r_ki[DW-1] ? (~r_ki + 1'b1) : r_ki)};
                n_mb  = r_integ[IW-1] ? (~r_integ + 1'b1) : r_integ;
                n_neg = r_ki[DW-1] ^ r_integ[IW-1];
                n_acc = '0;
                n_k   = '0;
            end
            pidc_pkg::U_MUL_D: begin
                n_ma  = {1'b0, (r_kd[DW-1] ? (~r_kd + 1'b1) : r_kd)};
                n_mb  = r_deriv[IW-1] ? (~r_deriv + 1'b1) : r_deriv;
                n_neg = r_kd[DW-1] ^ r_deriv[IW-1];
                n_acc = '0;
                n_k   = '0;
            end
            pidc_pkg::U_MUL_STEP: begin
                n_acc = r_acc + w_part_sh;
                n_k   = pidc_pkg::K_W'(r_k + 1'b1);
            end
            pidc_pkg::U_INTEG: begin
                // saturate to the 48-bit integral range
                if (w_isum[SW-1:IW-1] == '0 || w_isum[SW-1:IW-1] == '1) begin
                    n_integ = w_isum[IW-1:0];
                end else begin
                    n_integ = {w_isum[SW-1], {(IW - 1){~w_isum[SW-1]}}};
                end
            end
            pidc_pkg::U_DIV_SETUP: begin
                n_diff = w_diff;
                n_num  = {w_dmag[pidc_pkg::DIFF_W-2:0], {FW{1'b0}}};
                n_rem  = '0;
                n_quo  = '0;
                n_cnt  = pidc_pkg::DIV_FIRST;
            end
            pidc_pkg::U_DIV_STEP: begin
                n_rem = w_ge ? (w_rem_sh - {1'b0, r_dt}) : w_rem_sh;
                n_quo = {r_quo[pidc_pkg::NUM_W-2:0], w_ge};
                n_num = {r_num[pidc_pkg::NUM_W-2:0], 1'b0};
                n_cnt = pidc_pkg::CNT_W'(r_cnt - 1'b1);
            end
            pidc_pkg::U_DERIV: begin
                n_deriv = r_diff[pidc_pkg::DIFF_W-1]
                          ? -$signed({1'b0, w_qsat[IW-2:0]})
                          : $signed({1'b0, w_qsat[IW-2:0]});
                n_last  = r_err;
            end
            pidc_pkg::U_ACC: begin
                n_sum = r_sum + w_term;
            end
            pidc_pkg::U_OUT: begin
                if (w_out_free) begin
                    if (r_sum < w_lo) begin
                        n_drive = r_lower;
                    end else if (r_sum > w_hi) begin
                        n_drive = r_upper;
                    end else begin
                        n_drive = r_sum[DW-1:0];
                    end
                    n_out_valid = 1'b1;
                end
            end
            pidc_pkg::U_RST: begin
                if (w_out_free) begin
                    n_integ     = '0;
                    n_last      = '0;
                    n_drive     = '0;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= pidc_pkg::PC_FETCH;
            r_out_valid <= 1'b0;
            r_drive     <= '0;
            r_integ     <= '0;
            r_last      <= '0;
            r_kp        <= '0;
            r_ki        <= '0;
            r_kd        <= '0;
            r_upper     <= DW'(1) << FW;
            r_lower     <= -(DW'(1) << FW);
        end else begin
            r_pc        <= n_pc;
            r_out_valid <= n_out_valid;
            r_drive     <= n_drive;
            r_integ     <= n_integ;
            r_last      <= n_last;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    pidc_pkg::CFG_PROP:  r_kp    <= i_cfg_data;
                    pidc_pkg::CFG_INTEG: r_ki    <= i_cfg_data;
                    pidc_pkg::CFG_DERIV: r_kd    <= i_cfg_data;
                    pidc_pkg::CFG_UPPER: r_upper <= i_cfg_data;
                    pidc_pkg::CFG_LOWER: r_lower <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_err   <= n_err;
        r_dt    <= n_dt;
        r_diff  <= n_diff;
        r_deriv <= n_deriv;
        r_sum   <= n_sum;
        r_ma    <= n_ma;
        r_mb    <= n_mb;
        r_neg   <= n_neg;
        r_acc   <= n_acc;
        r_k     <= n_k;
        r_num   <= n_num;
        r_rem   <= n_rem;
        r_quo   <= n_quo;
        r_cnt   <= n_cnt;
    end

    // Checks on the sequencer
    `PIDC_ASSERT_NXT(a_accept_advances, i_clk, i_rst_n,
        i_in_valid && !o_in_stall, r_pc == pidc_pkg::PC_BRANCH)
    `PIDC_ASSERT_IMP(a_result_from_end, i_clk, i_rst_n, $rose(r_out_valid),
        $past(r_pc) == pidc_pkg::PC_OUT || $past(r_pc) == pidc_pkg::PC_RST)
    `PIDC_ASSERT_NXT(a_div_exit, i_clk, i_rst_n,
        r_pc == pidc_pkg::PC_DIV && r_cnt == '0, r_pc == pidc_pkg::PC_DERIV)

endmodule

`default_nettype wire

[verif/tb_top.sv]
// Self-checking testbench for the clamped PID controller: random and directed words, scored.
`timescale 1ns / 1ps

module tb_top;
    import pidc_pkg::*;

    localparam bit OP_COMPUTE = 1'b0;
    localparam bit OP_CLEAR   = 1'b1;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_WORDS = 800;
    localparam int RANDOM_PHASES = 6;

    // Predicts o_drive for every accepted word and checks it against the DUT
    class drive_scoreboard;
        localparam longint INTEG_HI = 64'sh0000_7FFF_FFFF_FFFF;
        localparam longint INTEG_LO = -INTEG_HI - 1;
        localparam logic [127:0] DERIV_LIM = 128'h7FFF_FFFF_FFFF;
        localparam logic [127:0] TERM_LIM  = 128'h1000_0000_0000_0000;

        longint kp, ki, kd, hi_bound, lo_bound;
        longint integ, prev_err;
        logic [DATA_W-1:0] pending_drive[$];
        int errors, checked, accepted, clears, zero_dt;

        function new();
            kp = 0;
            ki = 0;
            kd = 0;
            hi_bound = longint'(1) << FRAC_W;
            lo_bound = -(longint'(1) << FRAC_W);
            integ = 0;
            prev_err = 0;
            errors = 0;
            checked = 0;
            accepted = 0;
            clears = 0;
            zero_dt = 0;
        endfunction

        function int pending();
            return pending_drive.size();
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
            longint v;
            v = longint'($signed(val));
            case (idx)
                CFG_PROP:  kp = v;
                CFG_INTEG: ki = v;
                CFG_DERIV: kd = v;
                CFG_UPPER: hi_bound = v;
                CFG_LOWER: lo_bound = v;
                default: ;
            endcase
        endfunction

        // (a*b) >> FRAC_W on magnitudes, saturated, sign restored
        function longint scaled_product(longint a, longint b);
            logic [127:0] ma, mb, p;
            longint r;
            ma = 128'((a < 0) ? -a : a);
            mb = 128'((b < 0) ? -b : b);
            p = (ma * mb) >> FRAC_W;
            if (p > TERM_LIM)
                p = TERM_LIM;
            r = longint'(p[63:0]);
            return ((a < 0) != (b < 0)) ? -r : r;
        endfunction

        function void note_word(bit op, logic signed [DATA_W-1:0] sp,
                                logic signed [DATA_W-1:0] ms, logic [DT_W-1:0] el);
            longint err, dlt, deriv, acc, drv, dtv;
            logic [127:0] quo;
            accepted++;
            if (op == OP_CLEAR) begin
                clears++;
                integ = 0;
                prev_err = 0;
                pending_drive.push_back('0);
                return;
            end
            if (el == '0) begin
                zero_dt++;
                dtv = longint'(DT_MIN);
            end else begin
                dtv = longint'(el);
            end
            err = longint'(sp) - longint'(ms);

            // saturating integral
            acc = integ + scaled_product(err, dtv);
            if (acc > INTEG_HI)
                acc = INTEG_HI;
            else if (acc < INTEG_LO)
                acc = INTEG_LO;
            integ = acc;

            // derivative: (change << FRAC_W) / dt, truncated, saturated
            dlt = err - prev_err;
            quo = (128'((dlt < 0) ? -dlt : dlt) << FRAC_W) / 128'(dtv);
            if (quo > DERIV_LIM)
                quo = DERIV_LIM;
            deriv = (dlt < 0) ? -longint'(quo[63:0]) : longint'(quo[63:0]);
            prev_err = err;

            drv = scaled_product(kp, err) + scaled_product(ki, integ)
                + scaled_product(kd, deriv);
            if (drv < lo_bound)
                drv = lo_bound;
            else if (drv > hi_bound)
                drv = hi_bound;
            pending_drive.push_back(drv[DATA_W-1:0]);
        endfunction

        function void check_drive(logic [DATA_W-1:0] got);
            logic [DATA_W-1:0] want;
            if (pending_drive.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("[%0t] unexpected drive word 0x%08h", $realtime, got);
                return;
            end
            want = pending_drive.pop_front();
            checked++;
            if (got !== want) begin
                errors++;
                if (errors <= 10)
                    $display("[%0t] drive mismatch on result %0d: expected %0d (0x%08h) got %0d (0x%08h)",
                             $realtime, checked, $signed(want), want, $signed(got), got);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_op = 1'b0;
    logic [DATA_W-1:0] in_setpoint = '0;
    logic [DATA_W-1:0] in_measured = '0;
    logic [DT_W-1:0] in_elapsed = '0;
    logic out_stall = 1'b0;
    logic cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DATA_W-1:0] cfg_data = '0;
    wire o_in_stall, o_out_valid, o_cfg_ready;
    wire [DATA_W-1:0] o_drive;

    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int cycles = 0;
    drive_scoreboard sb;

    pid_controller_clamped dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_op        (in_op),
        .i_setpoint  (in_setpoint),
        .i_measured  (in_measured),
        .i_elapsed   (in_elapsed),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_drive     (o_drive),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver stalls at random
    always @(posedge clk) begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < sink_stall_pct);
    end

    // score accepted words on both channels
    always @(posedge clk) begin
        if (rst_n && in_valid && !o_in_stall)
            sb.note_word(in_op, in_setpoint, in_measured, in_elapsed);
        if (rst_n && o_out_valid && !out_stall)
            sb.check_drive(o_drive);
    end

    // watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
            $display("** pid_controller_clamped: FAILED **");
            $finish;
        end
    end

    // one word, with random idle cycles ahead of it
    task automatic push_word(bit op, logic [DATA_W-1:0] sp, logic [DATA_W-1:0] ms,
                             logic [DT_W-1:0] el);
        while ($urandom_range(99) < src_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_op <= op;
        in_setpoint <= sp;
        in_measured <= ms;
        in_elapsed <= el;
        do @(posedge clk); while (o_in_stall);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        // the monitor has scored the last accepted word after this edge
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!o_cfg_ready);
        sb.set_reg(idx, val);
    endtask

    task automatic apply_config(logic [DATA_W-1:0] p, logic [DATA_W-1:0] i,
                                logic [DATA_W-1:0] d, logic [DATA_W-1:0] up,
                                logic [DATA_W-1:0] lo);
        write_reg(CFG_PROP, p);
        write_reg(CFG_INTEG, i);
        write_reg(CFG_DERIV, d);
        write_reg(CFG_UPPER, up);
        write_reg(CFG_LOWER, lo);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(4))
            0: return $urandom();
            1: return DATA_W'($urandom_range(0, 20 * 65536)) - DATA_W'(10 * 65536);
            2: begin
                case ($urandom_range(3))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return '0;
                    default: return '1;
                endcase
            end
            default: return DATA_W'($urandom_range(0, 2 * 65536)) - DATA_W'(65536);
        endcase
    endfunction

    function automatic logic [DT_W-1:0] pick_elapsed();
        case ($urandom_range(9))
            0: return '0;
            1: return DT_W'($urandom_range(1, 64));
            2: return '1;
            3: return DT_W'($urandom());
            default: return DT_W'($urandom_range(65, 65536));
        endcase
    endfunction

    // mostly control-loop runs (clear, then measurement settling on target), some noise
    task automatic random_words(int count);
        int sent, len;
        longint tgt, meas;
        logic [DT_W-1:0] base_dt;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(99) < 75) begin
                len = $urandom_range(4, 16);
                push_word(OP_CLEAR, $urandom(), $urandom(), DT_W'($urandom()));
                sent++;
                tgt = longint'($signed(pick_value()));
                meas = longint'($signed(pick_value()));
                base_dt = pick_elapsed();
                for (int k = 0; k < len; k++) begin
                    push_word(OP_COMPUTE, tgt[DATA_W-1:0], meas[DATA_W-1:0],
                              ($urandom_range(9) == 0) ? '0 : base_dt);
                    sent++;
                    meas = meas + ((tgt - meas) >>> $urandom_range(1, 3))
                         + longint'($urandom_range(0, 512)) - 256;
                    meas = longint'($signed(meas[DATA_W-1:0]));
                end
            end else begin
                push_word(($urandom_range(99) < 10) ? OP_CLEAR : OP_COMPUTE,
                          pick_value(), pick_value(), pick_elapsed());
                sent++;
            end
        end
        drain();
    endtask

    // edge cases: zero dt, full-scale error, derivative and integral saturation
    task automatic directed_words();
        push_word(OP_CLEAR, '1, '1, '1);
        push_word(OP_COMPUTE, 32'h0001_0000, '0, '0);
        push_word(OP_COMPUTE, 32'h0000_8000, 32'h0000_4000, 31'd655);
        push_word(OP_COMPUTE, 32'h7FFF_FFFF, 32'h8000_0000, 31'd1);
        push_word(OP_COMPUTE, 32'h8000_0000, 32'h7FFF_FFFF, 31'd1);
        repeat (3)
            push_word(OP_COMPUTE, 32'h7FFF_FFFF, 32'h8000_0000, '1);
        repeat (4)
            push_word(OP_COMPUTE, 32'h8000_0000, 32'h7FFF_FFFF, '1);
        push_word(OP_CLEAR, '0, '0, '0);
        push_word(OP_COMPUTE, '0, '0, '0);
        push_word(OP_COMPUTE, 32'hAAAA_AAAA, 32'h5555_5555, 31'h2AAA_AAAA);
        push_word(OP_COMPUTE, 32'h5555_5555, 32'hAAAA_AAAA, 31'h5555_5555);
        push_word(OP_COMPUTE, '1, 32'h0000_0001, 31'd65536);
        push_word(OP_CLEAR, '0, '0, '0);
        drain();
    endtask

    initial begin
        logic [DATA_W-1:0] a, b;
        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults: zero gains give zero drive
        push_word(OP_COMPUTE, 32'h0003_0000, '0, '0);
        drain();

        apply_config(32'h0001_0000, 32'h0000_8000, 32'h0000_0100, 32'h0004_0000, 32'hFFFC_0000);
        directed_words();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: apply_config(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                32'h7FFF_FFFF, 32'h8000_0000);
                // inverted bounds: drive is always one of the two
                1: apply_config(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                                32'hFFFF_0000, 32'h0001_0000);
                2: apply_config(32'h0000_0001, 32'hFFFF_FFFF, '0, '0, '0);
                3: begin
                    a = $urandom();
                    b = $urandom();
                    if ($signed(a) < $signed(b))
                        apply_config($urandom(), $urandom(), $urandom(), b, a);
                    else
                        apply_config($urandom(), $urandom(), $urandom(), a, b);
                end
                4: apply_config(DATA_W'($urandom_range(0, 8 * 65536)) - DATA_W'(4 * 65536),
                                DATA_W'($urandom_range(0, 8 * 65536)) - DATA_W'(4 * 65536),
                                DATA_W'($urandom_range(0, 65536)) - DATA_W'(32768),
                                DATA_W'($urandom_range(1, 100 * 65536)),
                                -DATA_W'($urandom_range(1, 100 * 65536)));
                default: apply_config(32'h0002_0000, 32'h0000_4000, 32'h0000_0800,
                                      32'h7FFF_FFFF, 32'h8000_0000);
            endcase
            case (ph % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 60; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 60; end
                default: begin src_idle_pct = 24; sink_stall_pct = 24; end
            endcase
            random_words(RANDOM_WORDS / RANDOM_PHASES);
        end

        src_idle_pct = 0;
        sink_stall_pct = 0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        $display("run: %0d words in (%0d clears, %0d zero-dt computes), %0d drive words checked",
                 sb.accepted, sb.clears, sb.zero_dt, sb.checked);
        $display("run: %0d config settings incl. full-scale and inverted bounds, %0d failures",
                 RANDOM_PHASES + 1, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("** pid_controller_clamped: PASSED **");
        else
            $display("** pid_controller_clamped: FAILED **");
        $finish;
    end

endmodule
